// ===== rtl/rsi_pkg.sv =====
// rsi_pkg: shared types and fixed constants of the ray/sphere intersection block
// holds field widths, register indexes and the control word passed along the cell chains
// no dependencies
package rsi_pkg;

   localparam int POS_W = 32;   // positions and center coordinates
   localparam int DIR_W = 18;   // directions and normals
   localparam int RAD_W = 31;   // radius and distance
   localparam int VEC_W = POS_W + 1;   // center minus origin, exact
   localparam int QUO_W = 18;   // quotient bits formed by the normal divider

   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } rsi_csr_type;

   // control word travelling with each transaction down a chain
   typedef struct packed {
      logic valid;
      logic flag;
   } rsi_ctl_type;

endpackage

// ===== rtl/rsi_sqrt_cell.sv =====
// rsi_sqrt_cell: one restoring square root step, settles one root bit per cell
// depends on rsi_pkg for the control word
module rsi_sqrt_cell #(
   parameter int DLW  = 76,
   parameter int SQ_W = 38,
   parameter int BIT  = 0,
   parameter int SW   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsi_pkg::rsi_ctl_type up_ctl,
   input  logic [DLW-1:0]       up_rem,
   input  logic [SQ_W-1:0]      up_root,
   input  logic [SW-1:0]        up_side,
   output rsi_pkg::rsi_ctl_type dn_ctl,
   output logic [DLW-1:0]       dn_rem,
   output logic [SQ_W-1:0]      dn_root,
   output logic [SW-1:0]        dn_side
);
   localparam int EW = DLW + 1;

   logic [EW-1:0]   rem_ext;
   logic [EW-1:0]   trial;
   logic            take;
   logic [EW-1:0]   rem_diff;
   rsi_pkg::rsi_ctl_type ctl_ff;
   logic [DLW-1:0]  rem_ff, rem_in;
   logic [SQ_W-1:0] root_ff, root_in;
   logic [SW-1:0]   side_ff;

   always_comb begin
      rem_ext  = {1'b0, up_rem};
      // (2r + bit) * bit, with r holding only bits above this one
      trial    = (EW'(up_root) << (BIT + 1)) | (EW'(1) << (2 * BIT));
      take     = rem_ext >= trial;
      rem_diff = rem_ext - trial;
      rem_in   = take ? rem_diff[DLW-1:0] : up_rem;
      root_in  = take ? (up_root | (SQ_W'(1) << BIT)) : up_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= up_ctl;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= up_side;
   end

   assign dn_ctl  = ctl_ff;
   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_side = side_ff;
endmodule

// ===== rtl/rsi_div_cell.sv =====
// rsi_div_cell: one restoring division step for the three normal lanes
// depends on rsi_pkg for the control word, widths and the radius width
module rsi_div_cell #(
   parameter int NW  = 52,
   parameter int BIT = 0,
   parameter int SW  = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [rsi_pkg::RAD_W-1:0]        radius,
   input  rsi_pkg::rsi_ctl_type             up_ctl,
   input  logic [NW-1:0]                    up_rem  [3],
   input  logic [rsi_pkg::QUO_W-1:0]        up_quo  [3],
   input  logic [SW-1:0]                    up_side,
   output rsi_pkg::rsi_ctl_type             dn_ctl,
   output logic [NW-1:0]                    dn_rem  [3],
   output logic [rsi_pkg::QUO_W-1:0]        dn_quo  [3],
   output logic [SW-1:0]                    dn_side
);
   logic [NW-1:0]                dsr;
   logic [NW-1:0]                rem_ff [3], rem_in [3];
   logic [rsi_pkg::QUO_W-1:0]    quo_ff [3], quo_in [3];
   rsi_pkg::rsi_ctl_type         ctl_ff;
   logic [SW-1:0]                side_ff;

   always_comb begin
      dsr = NW'(radius) << BIT;
      for (int i = 0; i < 3; i++) begin
         if (up_rem[i] >= dsr) begin
            rem_in[i] = up_rem[i] - dsr;
            quo_in[i] = up_quo[i] | (rsi_pkg::QUO_W'(1) << BIT);
         end else begin
            rem_in[i] = up_rem[i];
            quo_in[i] = up_quo[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= up_ctl;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      side_ff <= up_side;
   end

   assign dn_ctl  = ctl_ff;
   assign dn_rem  = rem_ff;
   assign dn_quo  = quo_ff;
   assign dn_side = side_ff;
endmodule

// ===== rtl/ray_sphere_intersect_top.sv =====
// ray_sphere_intersect_top: pipelined ray against sphere test, one ray per cycle
// from start to rsp_valid a ray passes stages 1 to 5, the square root chain of SQ_W
// root bits, stages 6 and 7, the normal divider chain and the final stage; busy
// stays low; the length is set by the square root chain (one cell per root bit)
// and the normal divider chain (one cell per quotient bit); synchronous reset
// empties the pipeline and loads center 0 and radius 1.0; results cannot be stalled
// depends on rsi_pkg, rsi_sqrt_cell and rsi_div_cell
module ray_sphere_intersect_top #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // ray transactions
   input  logic                             start,
   output logic                             busy,
   input  logic signed [rsi_pkg::POS_W-1:0] req_origin_x,
   input  logic signed [rsi_pkg::POS_W-1:0] req_origin_y,
   input  logic signed [rsi_pkg::POS_W-1:0] req_origin_z,
   input  logic signed [rsi_pkg::DIR_W-1:0] req_dir_x,
   input  logic signed [rsi_pkg::DIR_W-1:0] req_dir_y,
   input  logic signed [rsi_pkg::DIR_W-1:0] req_dir_z,
   // result transactions
   output logic                             rsp_valid,
   output logic                             rsp_is_hit,
   output logic [rsi_pkg::RAD_W-1:0]        rsp_distance,
   output logic signed [rsi_pkg::POS_W-1:0] rsp_point_x,
   output logic signed [rsi_pkg::POS_W-1:0] rsp_point_y,
   output logic signed [rsi_pkg::POS_W-1:0] rsp_point_z,
   output logic signed [rsi_pkg::DIR_W-1:0] rsp_normal_x,
   output logic signed [rsi_pkg::DIR_W-1:0] rsp_normal_y,
   output logic signed [rsi_pkg::DIR_W-1:0] rsp_normal_z,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [1:0]                       csr_index,
   input  logic [31:0]                      csr_data
);
   localparam int F     = FRACTION_BITS;
   localparam int POS_W = rsi_pkg::POS_W;
   localparam int DIR_W = rsi_pkg::DIR_W;
   localparam int RAD_W = rsi_pkg::RAD_W;
   localparam int VEC_W = rsi_pkg::VEC_W;
   localparam int QW    = rsi_pkg::QUO_W;
   // dot product terms and their sum
   localparam int PD_W  = VEC_W + DIR_W;
   localparam int SUM_W = PD_W + 2;
   localparam int DVW   = SUM_W - F;
   // squares and the discriminant
   localparam int PV_W  = 2 * VEC_W;
   localparam int VV_W  = PV_W + 2;
   localparam int RQ_W  = 2 * RAD_W;
   localparam int BIG_W = (2 * DVW > VV_W) ? 2 * DVW : VV_W;
   localparam int SQ_W  = (BIG_W + 3) / 2;
   localparam int DLW   = 2 * SQ_W;
   // near root and hit point
   localparam int TW    = ((DVW > SQ_W) ? DVW : SQ_W) + 1;
   localparam int TD_W  = TW + DIR_W;
   localparam int PFW   = TD_W + 1;
   // normal divider
   localparam int NUM_W = VEC_W + F;
   localparam int NW    = ((NUM_W > RAD_W + QW) ? NUM_W : RAD_W + QW) + 1;
   localparam int NMAX_I = (F > 16) ? 131071 : (1 << F);
   localparam logic [QW-1:0] NMAX = QW'(NMAX_I);
   // side data widths of the two chains
   localparam int SQ_SW = DVW + 3 * POS_W + 3 * DIR_W;
   localparam int DV_SW = RAD_W + 3 * POS_W + 3 + 3 + 1;

   // configuration registers
   logic signed [POS_W-1:0] cen_ff [3];
   logic [RAD_W-1:0]        rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cen_ff[0] <= '0;
         cen_ff[1] <= '0;
         cen_ff[2] <= '0;
         rad_ff    <= RAD_W'(1) << F;
      end else if (csr_valid) begin
         unique case (rsi_pkg::rsi_csr_type'(csr_index))
            rsi_pkg::CSR_CENTER_X: cen_ff[0] <= csr_data;
            rsi_pkg::CSR_CENTER_Y: cen_ff[1] <= csr_data;
            rsi_pkg::CSR_CENTER_Z: cen_ff[2] <= csr_data;
            rsi_pkg::CSR_RADIUS:   rad_ff    <= csr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   // every stage advances every cycle, so a new ray is always welcome
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   logic signed [POS_W-1:0] org [3];
   logic signed [DIR_W-1:0] dir [3];
   assign org = '{req_origin_x, req_origin_y, req_origin_z};
   assign dir = '{req_dir_x, req_dir_y, req_dir_z};

   // stage 1: v = center - origin
   logic                    vld1_ff;
   logic signed [VEC_W-1:0] v1_ff [3];
   logic signed [POS_W-1:0] o1_ff [3];
   logic signed [DIR_W-1:0] d1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= accept;
      end
      for (int i = 0; i < 3; i++) begin
         v1_ff[i] <= VEC_W'(cen_ff[i]) - VEC_W'(org[i]);
         o1_ff[i] <= org[i];
         d1_ff[i] <= dir[i];
      end
   end

   // stage 2: per axis products dir*v and v*v
   logic                    vld2_ff;
   logic signed [PD_W-1:0]  pd2_ff [3];
   logic signed [PV_W-1:0]  pv2_ff [3];
   logic signed [POS_W-1:0] o2_ff [3];
   logic signed [DIR_W-1:0] d2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
      for (int i = 0; i < 3; i++) begin
         pd2_ff[i] <= d1_ff[i] * v1_ff[i];
         pv2_ff[i] <= v1_ff[i] * v1_ff[i];
      end
      o2_ff <= o1_ff;
      d2_ff <= d1_ff;
   end

   // stage 3: sum the three terms of each
   logic                    vld3_ff;
   logic signed [SUM_W-1:0] sum3_ff;
   logic signed [VV_W-1:0]  vv3_ff;
   logic signed [POS_W-1:0] o3_ff [3];
   logic signed [DIR_W-1:0] d3_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= vld2_ff;
      end
      sum3_ff <= SUM_W'(pd2_ff[0]) + SUM_W'(pd2_ff[1]) + SUM_W'(pd2_ff[2]);
      vv3_ff  <= VV_W'(pv2_ff[0]) + VV_W'(pv2_ff[1]) + VV_W'(pv2_ff[2]);
      o3_ff   <= o2_ff;
      d3_ff   <= d2_ff;
   end

   // stage 4: dv is the floored dot product, then dv^2 and r^2
   logic signed [DVW-1:0]   dv3;
   logic                    vld4_ff;
   logic signed [DVW-1:0]   dv4_ff;
   logic signed [2*DVW-1:0] dvsq4_ff;
   logic [RQ_W-1:0]         rsq4_ff;
   logic signed [VV_W-1:0]  vv4_ff;
   logic signed [POS_W-1:0] o4_ff [3];
   logic signed [DIR_W-1:0] d4_ff [3];

   // arithmetic shift floors, as the value fits in DVW bits
   assign dv3 = DVW'(sum3_ff >>> F);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else begin
         vld4_ff <= vld3_ff;
      end
      dv4_ff   <= dv3;
      dvsq4_ff <= dv3 * dv3;
      rsq4_ff  <= rad_ff * rad_ff;
      vv4_ff   <= vv3_ff;
      o4_ff    <= o3_ff;
      d4_ff    <= d3_ff;
   end

   // stage 5: reduced discriminant
   logic                    vld5_ff;
   logic signed [DLW-1:0]   delta5_ff;
   logic signed [DVW-1:0]   dv5_ff;
   logic signed [POS_W-1:0] o5_ff [3];
   logic signed [DIR_W-1:0] d5_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
      end else begin
         vld5_ff <= vld4_ff;
      end
      delta5_ff <= DLW'(dvsq4_ff) + DLW'(rsq4_ff) - DLW'(vv4_ff);
      dv5_ff    <= dv4_ff;
      o5_ff     <= o4_ff;
      d5_ff     <= d4_ff;
   end

   // square root chain, most significant root bit first
   rsi_pkg::rsi_ctl_type sq_ctl  [SQ_W+1];
   logic [DLW-1:0]       sq_rem  [SQ_W+1];
   logic [SQ_W-1:0]      sq_root [SQ_W+1];
   logic [SQ_SW-1:0]     sq_side [SQ_W+1];

   // flag marks a negative discriminant, which is a miss whatever the root
   assign sq_ctl[0].valid = vld5_ff;
   assign sq_ctl[0].flag  = delta5_ff[DLW-1];
   assign sq_rem[0]       = delta5_ff[DLW-1] ? '0 : delta5_ff;
   assign sq_root[0]      = '0;
   assign sq_side[0]      = {dv5_ff, o5_ff[0], o5_ff[1], o5_ff[2],
                             d5_ff[0], d5_ff[1], d5_ff[2]};

   for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
      rsi_sqrt_cell #(
         .DLW (DLW),
         .SQ_W(SQ_W),
         .BIT (SQ_W - 1 - k),
         .SW  (SQ_SW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .up_ctl (sq_ctl[k]),
         .up_rem (sq_rem[k]),
         .up_root(sq_root[k]),
         .up_side(sq_side[k]),
         .dn_ctl (sq_ctl[k+1]),
         .dn_rem (sq_rem[k+1]),
         .dn_root(sq_root[k+1]),
         .dn_side(sq_side[k+1])
      );
   end

   // unpack the far end of the root chain
   logic signed [DVW-1:0]   dv6;
   logic signed [POS_W-1:0] o6 [3];
   logic signed [DIR_W-1:0] d6 [3];
   logic signed [TW-1:0]    t6;
   logic                    hit6;

   assign {dv6, o6[0], o6[1], o6[2], d6[0], d6[1], d6[2]} = sq_side[SQ_W];
   assign t6   = TW'(dv6) - TW'(sq_root[SQ_W]);
   assign hit6 = !sq_ctl[SQ_W].flag && !t6[TW-1];

   // stage 6: near root and t*dir
   logic                    vld6_ff;
   logic                    hit6_ff;
   logic signed [TW-1:0]    t6_ff;
   logic signed [TD_W-1:0]  td6_ff [3];
   logic signed [POS_W-1:0] o6_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
      end else begin
         vld6_ff <= sq_ctl[SQ_W].valid;
      end
      hit6_ff <= hit6;
      t6_ff   <= t6;
      for (int i = 0; i < 3; i++) begin
         td6_ff[i] <= t6 * d6[i];
      end
      o6_ff <= o6;
   end

   // stage 7: hit point, saturated to the position range, and distance
   logic signed [PFW-1:0]   pf7 [3];
   logic signed [POS_W-1:0] pc7 [3];
   logic [RAD_W-1:0]        dist7;
   logic                    vld7_ff;
   logic                    hit7_ff;
   logic [RAD_W-1:0]        dist7_ff;
   logic signed [POS_W-1:0] p7_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pf7[i] = PFW'(o6_ff[i]) + PFW'(td6_ff[i] >>> F);
         // in range when every bit above the sign position agrees
         if (pf7[i][PFW-1:POS_W-1] == '0 || pf7[i][PFW-1:POS_W-1] == '1) begin
            pc7[i] = pf7[i][POS_W-1:0];
         end else if (pf7[i][PFW-1]) begin
            pc7[i] = {1'b1, {(POS_W-1){1'b0}}};
         end else begin
            pc7[i] = {1'b0, {(POS_W-1){1'b1}}};
         end
      end
      // t is non-negative on a hit, so only the upper limit applies
      dist7 = (t6_ff[TW-2:RAD_W] != '0) ? '1 : t6_ff[RAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld7_ff <= 1'b0;
      end else begin
         vld7_ff <= vld6_ff;
      end
      hit7_ff  <= hit6_ff;
      dist7_ff <= dist7;
      p7_ff    <= pc7;
   end

   // stage 8 feeds the divider: |p - c| * 2^F against the radius
   logic signed [VEC_W-1:0] df8 [3];
   logic [VEC_W-1:0]        mag8 [3];
   logic [NUM_W-1:0]        num8 [3];
   logic [2:0]              sgn8;
   logic [2:0]              ovf8;
   logic                    rz8;

   rsi_pkg::rsi_ctl_type dv_ctl  [QW+1];
   logic [NW-1:0]        dv_rem  [QW+1][3];
   logic [QW-1:0]        dv_quo  [QW+1][3];
   logic [DV_SW-1:0]     dv_side [QW+1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         df8[i]  = VEC_W'(p7_ff[i]) - VEC_W'(cen_ff[i]);
         mag8[i] = df8[i][VEC_W-1] ? VEC_W'(-df8[i]) : VEC_W'(df8[i]);
         num8[i] = NUM_W'(mag8[i]) << F;
         sgn8[i] = df8[i][VEC_W-1];
         // quotient beyond the divider's bits always saturates
         ovf8[i] = NW'(num8[i]) >= (NW'(rad_ff) << QW);
         dv_rem[0][i] = NW'(num8[i]);
         dv_quo[0][i] = '0;
      end
      rz8 = rad_ff == '0;
   end

   assign dv_ctl[0].valid = vld7_ff;
   assign dv_ctl[0].flag  = hit7_ff;
   assign dv_side[0]      = {dist7_ff, p7_ff[0], p7_ff[1], p7_ff[2], sgn8, ovf8, rz8};

   for (genvar k = 0; k < QW; k++) begin : g_div
      rsi_div_cell #(
         .NW (NW),
         .BIT(QW - 1 - k),
         .SW (DV_SW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .radius (rad_ff),
         .up_ctl (dv_ctl[k]),
         .up_rem (dv_rem[k]),
         .up_quo (dv_quo[k]),
         .up_side(dv_side[k]),
         .dn_ctl (dv_ctl[k+1]),
         .dn_rem (dv_rem[k+1]),
         .dn_quo (dv_quo[k+1]),
         .dn_side(dv_side[k+1])
      );
   end

   // final stage: clamp and sign the normal, zero everything on a miss
   logic [RAD_W-1:0]        dist9;
   logic signed [POS_W-1:0] p9 [3];
   logic [2:0]              sgn9;
   logic [2:0]              ovf9;
   logic                    rz9;
   logic                    hit9;
   logic [QW-1:0]           nm9 [3];
   logic signed [DIR_W-1:0] n9 [3];

   assign {dist9, p9[0], p9[1], p9[2], sgn9, ovf9, rz9} = dv_side[QW];
   assign hit9 = dv_ctl[QW].flag;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nm9[i] = (ovf9[i] || dv_quo[QW][i] > NMAX) ? NMAX : dv_quo[QW][i];
         if (rz9 || !hit9) begin
            n9[i] = '0;
         end else if (sgn9[i]) begin
            n9[i] = DIR_W'(-nm9[i]);
         end else begin
            n9[i] = DIR_W'(nm9[i]);
         end
      end
   end

   logic                    rv_ff;
   logic                    rhit_ff;
   logic [RAD_W-1:0]        rdist_ff;
   logic signed [POS_W-1:0] rp_ff [3];
   logic signed [DIR_W-1:0] rn_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= dv_ctl[QW].valid;
      end
      rhit_ff  <= hit9;
      rdist_ff <= hit9 ? dist9 : '0;
      for (int i = 0; i < 3; i++) begin
         rp_ff[i] <= hit9 ? p9[i] : '0;
      end
      rn_ff <= n9;
   end

   assign rsp_valid    = rv_ff;
   assign rsp_is_hit   = rhit_ff;
   assign rsp_distance = rdist_ff;
   assign rsp_point_x  = rp_ff[0];
   assign rsp_point_y  = rp_ff[1];
   assign rsp_point_z  = rp_ff[2];
   assign rsp_normal_x = rn_ff[0];
   assign rsp_normal_y = rn_ff[1];
   assign rsp_normal_z = rn_ff[2];
endmodule

// ===== rtl/rsi_checker.sv =====
// rsi_checker: port level checks for ray_sphere_intersect_top, bound to the top level
// depends on rsi_pkg and ray_sphere_intersect_top
module rsi_checker #(
   parameter int FRACTION_BITS = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             rsp_is_hit,
   input logic [rsi_pkg::RAD_W-1:0]        rsp_distance,
   input logic signed [rsi_pkg::POS_W-1:0] rsp_point_x,
   input logic signed [rsi_pkg::POS_W-1:0] rsp_point_y,
   input logic signed [rsi_pkg::POS_W-1:0] rsp_point_z,
   input logic signed [rsi_pkg::DIR_W-1:0] rsp_normal_x,
   input logic signed [rsi_pkg::DIR_W-1:0] rsp_normal_y,
   input logic signed [rsi_pkg::DIR_W-1:0] rsp_normal_z
);
   localparam int NMAX_I = (FRACTION_BITS > 16) ? 131071 : (1 << FRACTION_BITS);
   localparam logic signed [rsi_pkg::DIR_W-1:0] NMAX = rsi_pkg::DIR_W'(NMAX_I);
   localparam logic signed [rsi_pkg::DIR_W-1:0] NMIN = rsi_pkg::DIR_W'(-NMAX_I);

   // a miss carries nothing but the flag
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_hit |-> rsp_distance == '0 && rsp_point_x == '0 &&
      rsp_point_y == '0 && rsp_point_z == '0 && rsp_normal_x == '0 &&
      rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("miss result with non-zero payload");

   // normal components stay within the saturation limit
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x <= NMAX && rsp_normal_x >= NMIN &&
      rsp_normal_y <= NMAX && rsp_normal_y >= NMIN &&
      rsp_normal_z <= NMAX && rsp_normal_z >= NMIN)
      else $error("normal outside saturation range");

   // pipeline is empty straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // the pipeline never refuses a ray
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");
endmodule

bind ray_sphere_intersect_top rsi_checker #(
   .FRACTION_BITS(FRACTION_BITS)
) u_rsi_checker (
   .clock       (clock),
   .reset       (reset),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_is_hit  (rsp_is_hit),
   .rsp_distance(rsp_distance),
   .rsp_point_x (rsp_point_x),
   .rsp_point_y (rsp_point_y),
   .rsp_point_z (rsp_point_z),
   .rsp_normal_x(rsp_normal_x),
   .rsp_normal_y(rsp_normal_y),
   .rsp_normal_z(rsp_normal_z)
);

// ===== sim/ray_sphere_intersect_checker.sv =====
// ray_sphere_intersect_checker: watches the ray, result and register channels,
// predicts each result from its own fixed-point model and compares field by field
// depends on rsi_pkg
`timescale 1ns / 1ps
module ray_sphere_intersect_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic signed [rsi_pkg::POS_W-1:0] req_origin_x,
   input  logic signed [rsi_pkg::POS_W-1:0] req_origin_y,
   input  logic signed [rsi_pkg::POS_W-1:0] req_origin_z,
   input  logic signed [rsi_pkg::DIR_W-1:0] req_dir_x,
   input  logic signed [rsi_pkg::DIR_W-1:0] req_dir_y,
   input  logic signed [rsi_pkg::DIR_W-1:0] req_dir_z,
   input  logic                             rsp_valid,
   input  logic                             rsp_is_hit,
   input  logic [rsi_pkg::RAD_W-1:0]        rsp_distance,
   input  logic signed [rsi_pkg::POS_W-1:0] rsp_point_x,
   input  logic signed [rsi_pkg::POS_W-1:0] rsp_point_y,
   input  logic signed [rsi_pkg::POS_W-1:0] rsp_point_z,
   input  logic signed [rsi_pkg::DIR_W-1:0] rsp_normal_x,
   input  logic signed [rsi_pkg::DIR_W-1:0] rsp_normal_y,
   input  logic signed [rsi_pkg::DIR_W-1:0] rsp_normal_z,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [1:0]                       csr_index,
   input  logic [31:0]                      csr_data,
   input  logic                             at_end,
   output int                               fail_count,
   output int                               pending,
   output int                               hit_count,
   output int                               miss_count
);
   localparam int FB = 16;

   typedef struct packed {
      logic                             hit;
      logic [rsi_pkg::RAD_W-1:0]        distance;
      logic signed [rsi_pkg::POS_W-1:0] px, py, pz;
      logic signed [rsi_pkg::DIR_W-1:0] nx, ny, nz;
   } hit_record_type;

   logic signed [63:0] sph_c [3];
   logic [63:0]        sph_r;
   hit_record_type     expected_hits [$];

   function automatic logic signed [63:0] floor_div(logic signed [127:0] x);
      return 64'(x >>> FB);
   endfunction

   function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] clip(logic signed [63:0] x, logic signed [63:0] lo,
                                             logic signed [63:0] hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic hit_record_type trace_ray(logic signed [63:0] o [3],
                                                logic signed [63:0] d [3]);
      hit_record_type      res;
      logic signed [127:0] acc;
      logic signed [127:0] delta;
      logic signed [63:0]  v [3];
      logic signed [63:0]  dv, t, p, q;
      logic [63:0]         s;
      res = '0;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         v[i] = sph_c[i] - o[i];
         acc += 128'(d[i]) * 128'(v[i]);
      end
      dv = floor_div(acc);
      delta = 128'(dv) * 128'(dv) + $signed({64'd0, sph_r} * {64'd0, sph_r});
      for (int i = 0; i < 3; i++) delta -= 128'(v[i]) * 128'(v[i]);
      if (delta < 0) return res;
      s = isqrt(delta);
      t = dv - $signed(s);
      if (t < 0) return res;
      res.hit = 1'b1;
      res.distance = t > 64'sh7FFFFFFF ? 31'h7FFFFFFF : t[30:0];
      for (int i = 0; i < 3; i++) begin
         p = clip(o[i] + floor_div(128'(t) * 128'(d[i])), -64'sh80000000, 64'sh7FFFFFFF);
         if (sph_r == 0) q = 0;
         else q = clip(((p - sph_c[i]) * 64'sh10000) / $signed(sph_r), -64'sh10000, 64'sh10000);
         case (i)
            0: begin res.px = p[31:0]; res.nx = q[17:0]; end
            1: begin res.py = p[31:0]; res.ny = q[17:0]; end
            default: begin res.pz = p[31:0]; res.nz = q[17:0]; end
         endcase
      end
      return res;
   endfunction

   always @(posedge clock) begin
      logic signed [63:0] o [3];
      logic signed [63:0] d [3];
      hit_record_type     want, got;
      int                 errs;
      errs = 0;
      if (reset) begin
         sph_c[0] <= 0; sph_c[1] <= 0; sph_c[2] <= 0;
         sph_r <= 64'd65536;
         expected_hits.delete();
         fail_count <= 0; hit_count <= 0; miss_count <= 0;
         pending <= 0;
      end else begin
         // result before new ray: a same-edge ray can never be answered yet
         if (rsp_valid) begin
            got = {rsp_is_hit, rsp_distance, rsp_point_x, rsp_point_y, rsp_point_z,
                   rsp_normal_x, rsp_normal_y, rsp_normal_z};
            if (expected_hits.size() == 0) begin
               if (fail_count + errs < 10) $display("unexpected result transaction %h", got);
               errs++;
            end else begin
               want = expected_hits.pop_front();
               if (got.hit) hit_count <= hit_count + 1;
               else miss_count <= miss_count + 1;
               if (got !== want) begin
                  if (fail_count + errs < 10)
                     $display("mismatch: hit %b/%b dist %h/%h p %h %h %h / %h %h %h n %h %h %h / %h %h %h",
                              want.hit, got.hit, want.distance, got.distance,
                              want.px, want.py, want.pz,
                              got.px, got.py, got.pz, want.nx, want.ny, want.nz,
                              got.nx, got.ny, got.nz);
                  errs++;
               end
            end
         end
         if (start && !busy) begin
            o[0] = req_origin_x; o[1] = req_origin_y; o[2] = req_origin_z;
            d[0] = req_dir_x; d[1] = req_dir_y; d[2] = req_dir_z;
            expected_hits.push_back(trace_ray(o, d));
         end
         if (csr_valid && csr_ready) begin
            case (rsi_pkg::rsi_csr_type'(csr_index))
               rsi_pkg::CSR_CENTER_X: sph_c[0] <= $signed(csr_data);
               rsi_pkg::CSR_CENTER_Y: sph_c[1] <= $signed(csr_data);
               rsi_pkg::CSR_CENTER_Z: sph_c[2] <= $signed(csr_data);
               rsi_pkg::CSR_RADIUS:   sph_r <= {33'd0, csr_data[30:0]};
               default: ;
            endcase
         end
         if (at_end && expected_hits.size() != 0) begin
            if (fail_count + errs < 10)
               $display("%0d results never arrived", expected_hits.size());
            errs++;
            expected_hits.delete();
         end
         fail_count <= fail_count + errs;
         pending <= expected_hits.size();
      end
   end

endmodule

// ===== sim/ray_sphere_intersect_top_test.sv =====
// ray_sphere_intersect_top_test: stimulus and verdict for the ray/sphere block
// drives rays and register writes; checking lives in ray_sphere_intersect_checker
// depends on rsi_pkg, the block and the checker
`timescale 1ns / 1ps
module ray_sphere_intersect_top_test;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [rsi_pkg::POS_W-1:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic signed [rsi_pkg::DIR_W-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic rsp_valid, rsp_is_hit;
   logic [rsi_pkg::RAD_W-1:0] rsp_distance;
   logic signed [rsi_pkg::POS_W-1:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic signed [rsi_pkg::DIR_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic at_end = 1'b0;
   int fail_count, pending, hit_count, miss_count;
   int rays_sent = 0;

   // covers the pipeline depth at the default fraction width
   localparam int PIPE_DEPTH = 65;

   always #5 clock = ~clock;

   ray_sphere_intersect_top u_top (.*);
   ray_sphere_intersect_checker u_check (.*);

   // one register write, held until the channel takes it; the caller drops valid
   task automatic write_reg(rsi_pkg::rsi_csr_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic place_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] r);
      write_reg(rsi_pkg::CSR_CENTER_X, x);
      write_reg(rsi_pkg::CSR_CENTER_Y, y);
      write_reg(rsi_pkg::CSR_CENTER_Z, z);
      write_reg(rsi_pkg::CSR_RADIUS, r);
      csr_valid <= 1'b0;
   endtask

   // stop sending, drain pipeline completely, then allow its depth again
   task automatic wait_idle();
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // one ray transaction; start stays high into a following back-to-back ray
   task automatic cast_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [17:0] dx, logic [17:0] dy, logic [17:0] dz);
      int gap;
      start <= 1'b1;
      req_origin_x <= ox; req_origin_y <= oy; req_origin_z <= oz;
      req_dir_x <= dx; req_dir_y <= dy; req_dir_z <= dz;
      do @(posedge clock); while (busy);
      rays_sent++;
      // mostly no gap, sometimes short, rarely long
      gap = $urandom_range(0, 99);
      gap = gap < 60 ? 0 : (gap < 95 ? $urandom_range(1, 3) : $urandom_range(5, 40));
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // random unit-ish direction, with occasional raw bit noise to exercise every bit
   function automatic logic [17:0] rand_dir();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 18'($urandom);
      if (k == 1) return 18'($signed(k == 1 ? ($urandom_range(0, 1) ? 65536 : -65536) : 0));
      return 18'($signed($urandom_range(0, 131072)) - 65536);
   endfunction

   // ray aimed roughly at the sphere: origin near the centre, pulled back along -dir
   task automatic aimed_ray(logic signed [31:0] cx, logic signed [31:0] cy,
                            logic signed [31:0] cz, int spread);
      logic signed [17:0] dx, dy, dz;
      logic signed [63:0] back;
      dx = rand_dir(); dy = rand_dir(); dz = rand_dir();
      back = $urandom_range(0, 64);
      cast_ray(32'(cx - (back * dx) + $signed($urandom_range(0, 2 * spread)) - spread),
               32'(cy - (back * dy) + $signed($urandom_range(0, 2 * spread)) - spread),
               32'(cz - (back * dz)), dx, dy, dz);
   endtask

   initial begin
      logic signed [31:0] cx, cy, cz;
      logic [31:0] r;
      // reset at the start, only once
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset sphere, unit radius at origin
      cast_ray(-32'sd327680, 0, 0, 18'sd65536, 0, 0);     // straight hit
      cast_ray(32'sd327680, 0, 0, 18'sd65536, 0, 0);      // sphere behind
      cast_ray(0, 32'sd327680, 0, 18'sd65536, 0, 0);      // clean miss
      cast_ray(0, 0, 0, 0, 0, 18'sd65536);                // origin inside
      cast_ray(0, 0, 0, 0, 0, 0);                         // zero direction
      cast_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
               18'h20000, 18'h1FFFF, 18'h20000);          // field extremes
      cast_ray(-32'sd65536, 0, 0, 18'sd65536, 18'sd65536, 0); // non-unit direction
      wait_idle();
      // unit sphere far away: saturated distance
      place_sphere(32'h7FFFFFFF, 0, 0, 32'h00010000);
      cast_ray(32'h80000000, 0, 0, 18'sd65536, 0, 0);
      cast_ray(32'h80000000, 0, 0, -18'sd65536, 0, 0);
      wait_idle();
      place_sphere(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
      cast_ray(0, 0, 0, 0, 0, 18'sd65536);
      cast_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, -18'sd65536, 0, 0);
      cast_ray(0, 0, 0, 18'sd46341, 18'sd46341, 0);
      wait_idle();
      // zero radius, out of range but still accepted
      place_sphere(0, 0, 0, 0);
      cast_ray(-32'sd65536, 0, 0, 18'sd65536, 0, 0);
      cast_ray(0, 0, 0, 18'sd65536, 0, 0);
      wait_idle();
      // smallest legal radius, with an unused upper data bit set
      place_sphere(32'sd131072, 0, 0, 32'h80000001);
      cast_ray(0, 0, 0, 18'sd65536, 0, 0);
      cast_ray(32'sd131072, 0, 0, 0, 18'sd65536, 0);

      // random phases: new sphere each phase, mostly aimed rays plus noise
      for (int phase = 0; phase < 10; phase++) begin
         wait_idle();
         cx = $signed($urandom_range(0, 2000000)) - 1000000;
         cy = $signed($urandom_range(0, 2000000)) - 1000000;
         cz = $signed($urandom_range(0, 2000000)) - 1000000;
         r = $urandom_range(1, 4000000);
         if (phase == 9) begin cx = $urandom; cy = $urandom; cz = $urandom; r = $urandom; end
         place_sphere(cx, cy, cz, r);
         for (int k = 0; k < 125; k++) begin
            if ($urandom_range(0, 3) != 0) aimed_ray(cx, cy, cz, int'(r));
            else cast_ray($urandom, $urandom, $urandom, rand_dir(), rand_dir(), rand_dir());
         end
      end
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      at_end <= 1'b1;
      @(posedge clock);
      @(posedge clock);
      $display("%0d rays sent over 15 sphere settings: %0d hits, %0d misses",
               rays_sent, hit_count, miss_count);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule
